// File: sv/gcrb_pkg.sv
// Package for the great-circle range and bearing block: fixed-point formats,
// constants, the arctangent table, the pipeline slot type and its stage steps.
// Depends on nothing; every other file of the block imports it.
package gcrb_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int TRIG_ITERATIONS = 24;

  // Signed width of every Q30 datapath value.
  localparam int CW = 36;
  typedef logic signed [CW-1:0] cval_t;
  typedef logic signed [24:0] deg_t;

  localparam int FULL_TURN_I = 360 << ANGLE_FRAC_BITS;
  localparam int HALF_TURN_I = 180 << ANGLE_FRAC_BITS;

  localparam cval_t ONE_Q30     = 36'sd1073741824;
  localparam cval_t PI_Q30      = 36'sd3373259426;
  localparam cval_t HALF_PI_Q30 = 36'sd1686629713;
  localparam cval_t INV_GAIN    = 36'sd652032874;
  localparam logic [31:0] PI_U32      = 32'd3373259426;
  localparam logic [31:0] HALF_PI_U32 = 32'd1686629713;
  localparam logic [23:0] HALF_TURN_U = 24'(HALF_TURN_I);
  localparam logic [22:0] RANGE_MAX   = 23'h7FFFFF;

  // Degrees to radians: half a turn is 45 * 2^(ANGLE_FRAC_BITS+2).
  localparam int D2R_SHIFT = ANGLE_FRAC_BITS + 2;
  localparam logic [55:0] D2R_ROUND = 56'(90 << ANGLE_FRAC_BITS);
  localparam logic [6:0] D2R_DIV = 7'd45;
  localparam int DNUM_W = 38;
  // Floor of 2^DNUM_W / 45; the product estimate is at most one below the
  // true quotient, and one compare and subtract on the remainder fixes it.
  localparam logic [32:0] D45_RECIP = 33'((64'd1 << DNUM_W) / 64'(D2R_DIV));

  // Radians to degrees: floor of 2^56 / pi in Q30, used the same way.
  localparam logic [24:0] PI_RECIP = 25'((64'd1 << 56) / 64'(PI_U32));

  localparam logic [1:0] QUAD_NONE = 2'b00;
  localparam logic [1:0] QUAD_POS  = 2'b01;
  localparam logic [1:0] QUAD_NEG  = 2'b10;

  // Stage schedule of the back-end pipeline.
  localparam int ST_D2R_MUL = 0;
  localparam int ST_D2R_RND = 1;
  localparam int ST_D45_MUL = 2;
  localparam int ST_D45_EST = 3;
  localparam int ST_D45_REM = 4;
  localparam int ST_D45_FIX = 5;
  localparam int ST_QUAD    = 6;
  localparam int ST_ROT     = ST_QUAD + 1;
  localparam int ST_SCFIX   = ST_ROT + TRIG_ITERATIONS;
  localparam int ST_M1      = ST_SCFIX + 1;
  localparam int ST_M2      = ST_M1 + 1;
  localparam int ST_M3      = ST_M2 + 1;
  localparam int ST_M4      = ST_M3 + 1;
  localparam int ST_SQ      = ST_M4 + 1;
  localparam int SQ_STAGES  = 32;
  localparam int ST_VPRE    = ST_SQ + SQ_STAGES;
  localparam int ST_VEC     = ST_VPRE + 1;
  localparam int ST_P1      = ST_VEC + TRIG_ITERATIONS;
  localparam int ST_P2      = ST_P1 + 1;
  localparam int ST_PI_MUL  = ST_P2 + 1;
  localparam int ST_PI_EST  = ST_PI_MUL + 1;
  localparam int ST_PI_REM  = ST_PI_EST + 1;
  localparam int ST_PI_FIX  = ST_PI_REM + 1;
  localparam int ST_FIN     = ST_PI_FIX + 1;
  localparam int N_STAGES   = ST_FIN + 1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic       coin;
    deg_t [2:0] ang;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic                    coin;
    deg_t [2:0]              ang;
    logic [2:0]              neg;
    logic [2:0]              zero;
    logic [2:0][55:0]        dprod;
    logic [2:0][DNUM_W-1:0]  dnum;
    logic [2:0][51:0]        dph;
    logic [2:0][51:0]        dpl;
    logic [2:0][33:0]        dq;
    logic [2:0][6:0]         drm;
    logic [2:0][1:0]         quad;
    cval_t [2:0]             cx;
    cval_t [2:0]             cy;
    cval_t [2:0]             ca;
    cval_t                   m12;
    cval_t                   mcc;
    cval_t                   mby;
    cval_t                   mc1s2;
    cval_t                   msc;
    cval_t                   cv;
    cval_t                   bx;
    cval_t                   cl;
    logic [62:0]             sq_v;
    logic [62:0]             sq_r;
    cval_t [1:0]             vx;
    cval_t [1:0]             vy;
    cval_t [1:0]             vz;
    cval_t [1:0]             fixz;
    logic [1:0]              fixd;
    logic [44:0]             rprod;
    logic                    bneg;
    logic [55:0]             bprod;
    logic [22:0]             rng;
    logic [55:0]             bnum;
    logic [52:0]             bph;
    logic [52:0]             bpl;
    logic [25:0]             bq;
    logic [32:0]             brm;
    logic [24:0]             bdeg;
  } slot_t;

  function automatic cval_t atan_q30(input int i);
    case (i)
      0:  return 36'h03243F6A8;
      1:  return 36'h01DAC6705;
      2:  return 36'h00FADBAFC;
      3:  return 36'h007F56EA6;
      4:  return 36'h003FEAB76;
      5:  return 36'h001FFD55B;
      6:  return 36'h000FFFAAA;
      7:  return 36'h0007FFF55;
      8:  return 36'h0003FFFEA;
      9:  return 36'h0001FFFFD;
      10: return 36'h0000FFFFF;
      11: return 36'h00007FFFF;
      12: return 36'h00003FFFF;
      13: return 36'h00001FFFF;
      14: return 36'h00000FFFF;
      15: return 36'h000007FFF;
      16: return 36'h000003FFF;
      17: return 36'h000001FFF;
      18: return 36'h000000FFF;
      19: return 36'h0000007FF;
      20: return 36'h0000003FF;
      21: return 36'h0000001FF;
      22: return 36'h0000000FF;
      23: return 36'h00000007F;
      24: return 36'h00000003F;
      25: return 36'h00000001F;
      26: return 36'h00000000F;
      27: return 36'h000000007;
      28: return 36'h000000003;
      29: return 36'h000000001;
      default: return '0;
    endcase
  endfunction

  // Q30 product rounded half away from zero.
  function automatic cval_t mulq(input cval_t a, input cval_t b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] p;
    logic [34:0] r;
    ma = (a < 0) ? 32'(-a) : 32'(a);
    mb = (b < 0) ? 32'(-b) : 32'(b);
    p  = ma * mb;
    r  = 35'((p + 64'd536870912) >> 30);
    return ((a < 0) != (b < 0)) ? -cval_t'(36'(r)) : cval_t'(36'(r));
  endfunction

  // One pipeline stage; g is a constant per instance, so each stage keeps
  // only the logic of its own step.
  function automatic slot_t stage_op(input int g, input slot_t si, input logic [12:0] radius);
    slot_t       so;
    cval_t       x;
    cval_t       y;
    cval_t       a;
    cval_t       t;
    logic [23:0] dm;
    logic [32:0] q;
    logic [31:0] u1;
    logic [31:0] u2;
    logic [62:0] bitv;
    logic [62:0] sum;
    logic [39:0] rw45;
    logic [44:0] rw;
    logic [31:0] am;
    logic [56:0] nb;
    logic signed [25:0] b;
    int i;
    so = si;
    if (g == ST_D2R_MUL) begin
      for (int l = 0; l < 3; l++) begin
        a = 36'($signed(si.ang[l]));
        so.neg[l]  = (a < 0);
        so.zero[l] = (a == 0);
        dm = (a < 0) ? 24'(-a) : 24'(a);
        so.dprod[l] = dm * PI_U32;
      end
    end else if (g == ST_D2R_RND) begin
      for (int l = 0; l < 3; l++) begin
        so.dnum[l] = DNUM_W'((si.dprod[l] + D2R_ROUND) >> D2R_SHIFT);
      end
    end else if (g == ST_D45_MUL) begin
      for (int l = 0; l < 3; l++) begin
        so.dph[l] = si.dnum[l][37:19] * D45_RECIP;
        so.dpl[l] = si.dnum[l][18:0] * D45_RECIP;
      end
    end else if (g == ST_D45_EST) begin
      for (int l = 0; l < 3; l++) begin
        so.dq[l] = 34'(({1'b0, si.dph[l]} + 53'(si.dpl[l] >> 19)) >> 19);
      end
    end else if (g == ST_D45_REM) begin
      for (int l = 0; l < 3; l++) begin
        rw45 = 40'(si.dnum[l]) - 40'(si.dq[l]) * 40'(D2R_DIV);
        so.drm[l] = rw45[6:0];
      end
    end else if (g == ST_D45_FIX) begin
      for (int l = 0; l < 3; l++) begin
        if (si.drm[l] >= D2R_DIV) so.dq[l] = si.dq[l] + 34'd1;
      end
    end else if (g == ST_QUAD) begin
      for (int l = 0; l < 3; l++) begin
        q = si.dq[l][32:0];
        a = 36'(q);
        if (si.neg[l]) a = -a;
        so.quad[l] = QUAD_NONE;
        if (a > HALF_PI_Q30) begin
          a = a - HALF_PI_Q30;
          so.quad[l] = QUAD_POS;
        end else if (a < -HALF_PI_Q30) begin
          a = a + HALF_PI_Q30;
          so.quad[l] = QUAD_NEG;
        end
        so.ca[l] = a;
        so.cx[l] = INV_GAIN;
        so.cy[l] = '0;
      end
    end else if (g >= ST_ROT && g < ST_SCFIX) begin
      i = g - ST_ROT;
      for (int l = 0; l < 3; l++) begin
        x = si.cx[l];
        y = si.cy[l];
        a = si.ca[l];
        if (a >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          a = a - atan_q30(i);
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          a = a + atan_q30(i);
        end
        so.cx[l] = t;
        so.cy[l] = y;
        so.ca[l] = a;
      end
    end else if (g == ST_SCFIX) begin
      // Sine goes to cy, cosine to cx.
      for (int l = 0; l < 3; l++) begin
        x = si.cx[l];
        y = si.cy[l];
        if (si.zero[l]) begin
          so.cy[l] = '0;
          so.cx[l] = ONE_Q30;
        end else begin
          case (si.quad[l])
            QUAD_POS: begin
              so.cy[l] = x;
              so.cx[l] = -y;
            end
            QUAD_NEG: begin
              so.cy[l] = -x;
              so.cx[l] = y;
            end
            default: begin
              so.cy[l] = y;
              so.cx[l] = x;
            end
          endcase
        end
      end
    end else if (g == ST_M1) begin
      so.m12   = mulq(si.cy[0], si.cy[1]);
      so.mcc   = mulq(si.cx[0], si.cx[1]);
      so.mby   = mulq(si.cy[2], si.cx[1]);
      so.mc1s2 = mulq(si.cx[0], si.cy[1]);
      so.msc   = mulq(si.cy[0], si.cx[1]);
    end else if (g == ST_M2) begin
      so.cv = si.m12 + mulq(si.mcc, si.cx[2]);
      so.bx = si.mc1s2 - mulq(si.msc, si.cx[2]);
    end else if (g == ST_M3) begin
      a = si.cv;
      if (a > ONE_Q30) a = ONE_Q30;
      if (a < -ONE_Q30) a = -ONE_Q30;
      so.cl = a;
    end else if (g == ST_M4) begin
      u1 = 32'(ONE_Q30 - si.cl);
      u2 = 32'(ONE_Q30 + si.cl);
      so.sq_v = u1 * u2;
      so.sq_r = '0;
    end else if (g >= ST_SQ && g < ST_VPRE) begin
      i = g - ST_SQ;
      bitv = 63'(1) << (62 - 2 * i);
      sum = si.sq_r + bitv;
      if (si.sq_v >= sum) begin
        so.sq_v = si.sq_v - sum;
        so.sq_r = (si.sq_r >> 1) + bitv;
      end else begin
        so.sq_r = si.sq_r >> 1;
      end
    end else if (g == ST_VPRE) begin
      for (int l = 0; l < 2; l++) begin
        if (l == 0) begin
          y = 36'(si.sq_r[30:0]);
          x = si.cl;
        end else begin
          y = si.mby;
          x = si.bx;
        end
        so.fixd[l] = 1'b0;
        so.fixz[l] = '0;
        if (y == 0) begin
          so.fixd[l] = 1'b1;
          so.fixz[l] = (x < 0) ? PI_Q30 : '0;
        end else if (x == 0) begin
          so.fixd[l] = 1'b1;
          so.fixz[l] = (y > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;
        end
        so.vz[l] = '0;
        if (x < 0) begin
          if (y > 0) begin
            so.vy[l] = -x;
            so.vx[l] = y;
            so.vz[l] = HALF_PI_Q30;
          end else begin
            so.vy[l] = x;
            so.vx[l] = -y;
            so.vz[l] = -HALF_PI_Q30;
          end
        end else begin
          so.vx[l] = x;
          so.vy[l] = y;
        end
      end
    end else if (g >= ST_VEC && g < ST_P1) begin
      i = g - ST_VEC;
      for (int l = 0; l < 2; l++) begin
        x = si.vx[l];
        y = si.vy[l];
        a = si.vz[l];
        if (y >= 0) begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          a = a + atan_q30(i);
        end else begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          a = a - atan_q30(i);
        end
        so.vx[l] = t;
        so.vy[l] = y;
        so.vz[l] = a;
      end
    end else if (g == ST_P1) begin
      a = si.fixd[0] ? si.fixz[0] : si.vz[0];
      if (a < 0) a = '0;
      am = a[31:0];
      so.rprod = am * radius;
      a = si.fixd[1] ? si.fixz[1] : si.vz[1];
      so.bneg = (a < 0);
      am = (a < 0) ? 32'(-a) : 32'(a);
      so.bprod = am * HALF_TURN_U;
    end else if (g == ST_P2) begin
      rw = 45'((si.rprod + 45'd2097152) >> 22);
      so.rng = (rw > 45'(RANGE_MAX)) ? RANGE_MAX : rw[22:0];
      nb = 57'(si.bprod) + 57'(HALF_PI_U32);
      so.bnum = nb[55:0];
    end else if (g == ST_PI_MUL) begin
      so.bph = si.bnum[55:28] * PI_RECIP;
      so.bpl = si.bnum[27:0] * PI_RECIP;
    end else if (g == ST_PI_EST) begin
      so.bq = 26'(({1'b0, si.bph} + 54'(si.bpl >> 28)) >> 28);
    end else if (g == ST_PI_REM) begin
      nb = 57'(si.bq) * 57'(PI_U32);
      nb = 57'(si.bnum) - nb;
      so.brm = nb[32:0];
    end else if (g == ST_PI_FIX) begin
      if (si.brm >= 33'(PI_U32)) so.bq = si.bq + 26'd1;
    end else if (g == ST_FIN) begin
      b = 26'(si.bq);
      if (si.bneg) b = -b;
      if (b < 0) b = b + 26'(FULL_TURN_I);
      if (b < 0) b = '0;
      if (b >= 26'(FULL_TURN_I)) b = b - 26'(FULL_TURN_I);
      if (b >= 26'(FULL_TURN_I)) b = '0;
      so.bdeg = b[24:0];
      if (si.coin) begin
        so.rng  = '0;
        so.bdeg = '0;
      end
    end
    return so;
  endfunction

endpackage

// File: sv/gcrb_front.sv
// Front end: accepts position pairs, reduces the longitude difference into
// (-180,180] and flags coincident points. Depends on gcrb_pkg.
module gcrb_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [23:0]       origin_lat,
  input  logic [24:0]       origin_lon,
  input  logic [23:0]       target_lat,
  input  logic [24:0]       target_lon,
  input  gcrb_pkg::q_stat_t q_stat,
  output logic              push,
  output gcrb_pkg::item_t   item
);
  import gcrb_pkg::*;

  localparam logic signed [26:0] FULL_S = 27'(FULL_TURN_I);
  localparam logic signed [26:0] HALF_S = 27'(HALF_TURN_I);

  logic signed [26:0] dl;
  logic signed [26:0] r;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    dl = 27'($signed(target_lon)) - 27'($signed(origin_lon));
    if (dl >= FULL_S) begin
      r = dl - FULL_S;
    end else if (dl <= -FULL_S) begin
      r = dl + FULL_S;
    end else begin
      r = dl;
    end
    if (r > HALF_S) begin
      r = r - FULL_S;
    end else if (r <= -HALF_S) begin
      r = r + FULL_S;
    end
    // Latitudes of 24 bits always lie within half a turn already.
    item.ang[0] = 25'($signed(origin_lat));
    item.ang[1] = 25'($signed(target_lat));
    item.ang[2] = r[24:0];
    item.coin   = (origin_lat == target_lat) && (r == 0);
  end

endmodule

// File: sv/gcrb_queue.sv
// Short queue between the front end and the back-end pipeline.
// Depends on gcrb_pkg for the item and status types.
module gcrb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  gcrb_pkg::item_t   wr_item,
  input  logic              pop,
  output gcrb_pkg::item_t   rd_item,
  output gcrb_pkg::q_stat_t q_stat
);
  import gcrb_pkg::*;

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign q_stat.full  = (count == (QPTR_W + 1)'(QDEPTH));
  assign q_stat.empty = (count == '0);
  assign rd_item      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/gcrb_back.sv
// Back end: the stage pipeline that turns a classified item into range and
// bearing, ending in the output register. Depends on gcrb_pkg.
module gcrb_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [12:0]       radius,
  input  gcrb_pkg::item_t   rd_item,
  input  gcrb_pkg::q_stat_t q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [22:0]       range_km,
  output logic [24:0]       bearing_deg
);
  import gcrb_pkg::*;

  slot_t               stg [N_STAGES];
  logic [N_STAGES-1:0] vld;
  slot_t               in_slot;
  logic                en;

  // The whole pipeline moves unless the output register is held.
  assign en  = !vld[N_STAGES-1] || out_ready;
  assign pop = en && !q_stat.empty;

  always_comb begin
    in_slot      = '0;
    in_slot.coin = rd_item.coin;
    in_slot.ang  = rd_item.ang;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N_STAGES-2:0], !q_stat.empty};
    end
  end

  for (genvar g = 0; g < N_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) stg[g] <= stage_op(g, in_slot, radius);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) stg[g] <= stage_op(g, stg[g-1], radius);
      end
    end
  end

  assign out_valid   = vld[N_STAGES-1];
  assign range_km    = stg[N_STAGES-1].rng;
  assign bearing_deg = stg[N_STAGES-1].bdeg;

endmodule

// File: sv/great_circle_range_bearing.sv
// Top level of the great-circle range and bearing block: radius register,
// front end, queue and back-end pipeline. Depends on gcrb_pkg, gcrb_front,
// gcrb_queue and gcrb_back.
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ----------------------------------------------
//  input    in_valid / in_ready    origin_lat, origin_lon, target_lat, target_lon
//  output   out_valid / out_ready  range_km, bearing_deg
//  config   cfg_valid / cfg_ready  earth_radius_km
//
// One position pair is taken in every cycle while the queue is not full,
// and one result leaves every cycle while the output is not held; the
// pipeline of the back end is N_STAGES (100) stages deep.
// The depth is set by the two CORDIC passes and the bit-serial square root;
// the divisions by 45 and by pi are reciprocal products over four stages each.
// Reset is synchronous and clears only the queue pointers and count and the
// stage valid bits; the radius returns to 6371.
// A held output register stalls the whole back end, and the queue then
// fills before in_ready drops.
module great_circle_range_bearing (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] origin_lat,
  input  logic [24:0] origin_lon,
  input  logic [23:0] target_lat,
  input  logic [24:0] target_lon,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [22:0] range_km,
  output logic [24:0] bearing_deg,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] earth_radius_km
);
  import gcrb_pkg::*;

  logic [12:0] radius;
  logic        push;
  logic        pop;
  item_t       wr_item;
  item_t       rd_item;
  q_stat_t     q_stat;

  // The radius register takes a write in any cycle, unchecked; the user must write
  // it only while the block is idle, so no item sees a change half way through.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 13'd6371;
    end else if (cfg_valid) begin
      radius <= earth_radius_km;
    end
  end

  // The front end classifies each transaction and writes it to the queue.
  gcrb_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .origin_lat (origin_lat),
    .origin_lon (origin_lon),
    .target_lat (target_lat),
    .target_lon (target_lon),
    .q_stat     (q_stat),
    .push       (push),
    .item       (wr_item)
  );

  // The queue lets the front end keep accepting while the back end stalls.
  gcrb_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .q_stat  (q_stat)
  );

  // The back end carries out the trigonometry and holds the result.
  gcrb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .radius      (radius),
    .rd_item     (rd_item),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .range_km    (range_km),
    .bearing_deg (bearing_deg)
  );

endmodule
